// ===== src/astar_pkg.sv =====
// Shared types, constants and command codes for the A* bookkeeping engine.
package astar_pkg;

    localparam int GRID_SIDE  = 64;
    localparam int OPEN_DEPTH = 256;
    localparam int MAX_PATH   = 64;
    localparam int COST_BITS  = 24;

    localparam int COORD_W  = $clog2(GRID_SIDE);
    localparam int CELL_W   = 2 * COORD_W;
    localparam int NCELLS   = GRID_SIDE * GRID_SIDE;
    localparam int OPEN_W   = $clog2(OPEN_DEPTH);
    localparam int OCNT_W   = $clog2(OPEN_DEPTH + 1);
    localparam int PATH_W   = $clog2(MAX_PATH + 1);
    localparam int SUM_W    = COST_BITS + 1;

    typedef enum logic [2:0] {
        CMD_SEED        = 3'd0,
        CMD_EXPLORE     = 3'd1,
        CMD_PEEK        = 3'd2,
        CMD_POP         = 3'd3,
        CMD_RECONSTRUCT = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_e;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  node_x;
        logic [5:0]  node_y;
        logic [5:0]  parent_x;
        logic [5:0]  parent_y;
        logic [23:0] node_cost;
        logic [23:0] node_heuristic;
    } in_beat_t;

    typedef struct packed {
        logic [5:0]  out_x;
        logic [5:0]  out_y;
        logic [23:0] out_cost;
        logic [23:0] out_heuristic;
        logic        existed;
        logic        is_stuck;
        logic [8:0]  open_count;
        logic [1:0]  status;
        logic        last;
    } out_beat_t;

    // One open list entry as held by a cell.
    typedef struct packed {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [COST_BITS-1:0] cost;
        logic [COST_BITS-1:0] heur;
    } open_rec_t;

    // Control from the sequencer to the cell row.
    typedef struct packed {
        logic      clear;     // empty every cell
        logic      push;      // append at the tail
        logic      remove;    // drop entry at remove_idx, later ones shift down
        logic [OPEN_W-1:0] remove_idx;
        open_rec_t push_rec;
    } row_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED,
        S_EXP_RD,
        S_EXP_WAIT,
        S_EXP_DO,
        S_SCAN,
        S_BEST_OUT,
        S_REC_RD,
        S_REC_WAIT,
        S_REC_EMIT,
        S_OUT
    } state_e;

endpackage

// ===== src/astar_open_list_and_parents.sv =====
// Top level of the A* bookkeeping engine: open list row, parent table, sequencer.
//
//   channel | direction | payload      | handshake
//   --------+-----------+--------------+-------------------------------
//   in      | into      | in_beat_t    | in_valid / in_stall
//   out     | out of    | out_beat_t   | out_valid / out_stall
//
// One command is worked at a time; in_stall is low only while the block is idle.
// Explore reads the parent table through its registered read port, decides, loads
// the output register and presents the beat before returning to idle.
// Peek and pop scan one cell per cycle through the row's registered read port.
// Reconstruct reads the table entry of each path cell in turn and emits a beat per
// cell. Seed clears the 4096-entry table one entry a cycle; after reset the same
// clearing pass runs before the first beat is taken. A result beat waits in the
// output register while out_stall is high.
module astar_open_list_and_parents
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  astar_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output astar_pkg::out_beat_t out_data
);
    import astar_pkg::*;

    localparam int TBL_W = 1 + CELL_W + COST_BITS;

    state_e state_reg, state_next;
    in_beat_t cmd_reg;
    logic [CELL_W:0]        sweep_reg, sweep_next;
    logic [OCNT_W-1:0]      size_reg, size_next;
    logic [OPEN_W-1:0]      idx_reg, idx_next;
    logic [OPEN_W-1:0]      best_idx_reg, best_idx_next;
    logic [SUM_W-1:0]       best_sum_reg, best_sum_next;
    open_rec_t              best_rec_reg, best_rec_next;
    logic                   scan_first_reg, scan_first_next;
    logic [CELL_W-1:0]      cur_reg, cur_next;
    logic [PATH_W-1:0]      pcount_reg, pcount_next;
    out_beat_t              out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    state_e                 ret_reg, ret_next;

    // Parent table: known bit, parent cell and recorded cost per cell.
    logic               tbl_we;
    logic [CELL_W-1:0]  tbl_waddr, tbl_raddr;
    logic [TBL_W-1:0]   tbl_wdata, tbl_rdata;
    logic               t_known;
    logic [CELL_W-1:0]  t_par;
    logic [COST_BITS-1:0] t_cost;

    astar_ram #(.WIDTH(TBL_W), .DEPTH(NCELLS)) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );
    assign {t_known, t_par, t_cost} = tbl_rdata;

    row_ctl_t   ctl;
    open_rec_t  rd_rec;
    logic [SUM_W-1:0] rd_sum;

    astar_row u_row (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .tail   (size_reg[OPEN_W-1:0]),
        .rd_idx (idx_reg),
        .rd_rec (rd_rec)
    );
    assign rd_sum = SUM_W'(rd_rec.cost) + SUM_W'(rd_rec.heur);

    logic [CELL_W-1:0] node_c, par_c;
    assign node_c = {cmd_reg.node_y, cmd_reg.node_x};
    assign par_c  = {cmd_reg.parent_y, cmd_reg.parent_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            sweep_reg     <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            sweep_reg     <= sweep_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            cmd_reg <= in_data;
        end
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        best_sum_reg   <= best_sum_next;
        best_rec_reg   <= best_rec_next;
        scan_first_reg <= scan_first_next;
        cur_reg        <= cur_next;
        pcount_reg     <= pcount_next;
        out_reg        <= out_next;
    end

    function automatic out_beat_t mk(input logic [CELL_W-1:0] c,
                                     input logic [COST_BITS-1:0] cost,
                                     input logic ex, input status_e st,
                                     input logic [OCNT_W-1:0] sz,
                                     input logic lst);
        out_beat_t o;
        o.out_x         = c[COORD_W-1:0];
        o.out_y         = c[CELL_W-1:COORD_W];
        o.out_cost      = cost;
        o.out_heuristic = '0;
        o.existed       = ex;
        o.is_stuck      = (sz == '0);
        o.open_count    = sz;
        o.status        = st;
        o.last          = lst;
        return o;
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        sweep_next      = sweep_reg;
        size_next       = size_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_sum_next   = best_sum_reg;
        best_rec_next   = best_rec_reg;
        scan_first_next = scan_first_reg;
        cur_next        = cur_reg;
        pcount_next     = pcount_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        in_stall        = 1'b1;
        tbl_we          = 1'b0;
        tbl_waddr       = cur_reg;
        tbl_wdata       = '0;
        tbl_raddr       = cur_reg;
        ctl             = '0;
        ctl.remove_idx  = best_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (in_data.cmd)
                        CMD_SEED:
                        begin
                            sweep_next = '0;
                            ret_next   = S_SEED;
                            state_next = S_CLEAR;
                        end
                        CMD_EXPLORE:     state_next = S_EXP_RD;
                        CMD_PEEK, CMD_POP:
                        begin
                            idx_next        = '0;
                            scan_first_next = 1'b1;
                            state_next      = S_SCAN;
                        end
                        CMD_RECONSTRUCT:
                        begin
                            cur_next    = {in_data.node_y, in_data.node_x};
                            pcount_next = '0;
                            state_next  = S_REC_RD;
                        end
                        default:
                        begin
                            out_next   = mk('0, '0, 1'b0, ST_OK, size_reg, 1'b1);
                            state_next = S_OUT;
                            ret_next   = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = sweep_reg[CELL_W-1:0];
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[CELL_W])
                begin
                    // The pass after reset returns to idle; a seed goes on.
                    tbl_we     = 1'b0;
                    sweep_next = '0;
                    state_next = (ret_reg == S_SEED) ? S_SEED : S_IDLE;
                end
            end
            S_SEED:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = node_c;
                tbl_wdata = {1'b1, node_c, {COST_BITS{1'b0}}};
                ctl.clear = 1'b1;
                size_next = '0;
                out_next  = mk(node_c, '0, 1'b0, ST_OK, OCNT_W'(1), 1'b1);
                state_next = S_BEST_OUT;   // reuse: load row entry then emit
            end
            S_EXP_RD:
            begin
                tbl_raddr  = node_c;
                state_next = S_EXP_WAIT;
            end
            S_EXP_WAIT:
            begin
                tbl_raddr  = node_c;
                state_next = S_EXP_DO;
            end
            S_EXP_DO:
            begin
                ret_next   = S_IDLE;
                state_next = S_OUT;
                tbl_waddr  = node_c;
                if (!t_known)
                begin
                    if (size_reg >= OCNT_W'(OPEN_DEPTH))
                    begin
                        out_next = mk(node_c, '0, 1'b0, ST_FULL, size_reg, 1'b1);
                    end
                    else
                    begin
                        tbl_we   = 1'b1;
                        tbl_wdata = {1'b1, par_c, cmd_reg.node_cost};
                        ctl.push = 1'b1;
                        ctl.push_rec = '{x: cmd_reg.node_x, y: cmd_reg.node_y,
                                         cost: cmd_reg.node_cost,
                                         heur: cmd_reg.node_heuristic};
                        size_next = size_reg + 1'b1;
                        out_next  = mk(node_c, cmd_reg.node_cost, 1'b0, ST_OK,
                                       size_reg + 1'b1, 1'b1);
                    end
                end
                else if (cmd_reg.node_cost < t_cost)
                begin
                    tbl_we    = 1'b1;
                    tbl_wdata = {1'b1, par_c, cmd_reg.node_cost};
                    out_next  = mk(node_c, cmd_reg.node_cost, 1'b1, ST_OK,
                                   size_reg, 1'b1);
                end
                else
                begin
                    out_next = mk(node_c, t_cost, 1'b1, ST_OK, size_reg, 1'b1);
                end
            end
            S_SCAN:
            begin
                // rd_rec shows the entry addressed in the previous cycle.
                if (size_reg == '0)
                begin
                    out_next   = mk('0, '0, 1'b0, ST_EMPTY, size_reg, 1'b1);
                    ret_next   = S_IDLE;
                    state_next = S_OUT;
                end
                else
                begin
                    scan_first_next = 1'b0;
                    if (!scan_first_reg)
                    begin
                        if (pcount_reg == '0 || rd_sum < best_sum_reg)
                        begin
                            best_sum_next = rd_sum;
                            best_rec_next = rd_rec;
                            best_idx_next = idx_reg - 1'b1;
                        end
                        pcount_next = PATH_W'(1);
                    end
                    else
                    begin
                        pcount_next = '0;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (!scan_first_reg &&
                        ({1'b0, idx_reg} == OCNT_W'(size_reg) ||
                         (idx_reg == '0)))
                    begin
                        state_next = S_BEST_OUT;
                    end
                end
            end
            S_BEST_OUT:
            begin
                ret_next   = S_IDLE;
                state_next = S_OUT;
                if (cmd_reg.cmd == CMD_SEED)
                begin
                    ctl.push     = 1'b1;
                    ctl.push_rec = '{x: cmd_reg.node_x, y: cmd_reg.node_y,
                                     cost: '0, heur: cmd_reg.node_heuristic};
                    size_next    = OCNT_W'(1);
                end
                else
                begin
                    if (cmd_reg.cmd == CMD_POP)
                    begin
                        ctl.remove = 1'b1;
                        size_next  = size_reg - 1'b1;
                    end
                    out_next = mk({best_rec_reg.y, best_rec_reg.x},
                                  best_rec_reg.cost, 1'b0, ST_OK,
                                  (cmd_reg.cmd == CMD_POP) ? size_reg - 1'b1
                                                           : size_reg, 1'b1);
                    out_next.out_heuristic = best_rec_reg.heur;
                end
            end
            S_REC_RD:
            begin
                state_next = S_REC_WAIT;
            end
            S_REC_WAIT:
            begin
                state_next = S_REC_EMIT;
            end
            S_REC_EMIT:
            begin
                state_next  = S_OUT;
                pcount_next = pcount_reg + 1'b1;
                if (!t_known)
                begin
                    // Only reachable for the first cell; later cells are checked
                    // before they are followed.
                    out_next = mk(cur_reg, '0, 1'b0, ST_TRUNCATED, size_reg, 1'b1);
                    ret_next = S_IDLE;
                end
                else if (t_par == cur_reg)
                begin
                    out_next = mk(cur_reg, t_cost, 1'b0, ST_OK, size_reg, 1'b1);
                    ret_next = S_IDLE;
                end
                else if (pcount_reg + 1'b1 >= PATH_W'(MAX_PATH))
                begin
                    out_next = mk(cur_reg, t_cost, 1'b0, ST_TRUNCATED, size_reg,
                                  1'b1);
                    ret_next = S_IDLE;
                end
                else
                begin
                    // Need the parent's known bit before this beat's last flag.
                    out_next = mk(cur_reg, t_cost, 1'b0, ST_OK, size_reg, 1'b0);
                    cur_next = t_par;
                    ret_next = S_REC_RD;
                    tbl_raddr  = t_par;
                end
            end
            S_OUT:
            begin
                // Path beats wait here for the parent's known bit.
                if (ret_reg == S_REC_RD && !out_valid_reg)
                begin
                    if (!t_known)
                    begin
                        out_next.status = ST_TRUNCATED;
                        out_next.last   = 1'b1;
                        ret_next        = S_IDLE;
                    end
                    out_valid_next = 1'b1;
                end
                else if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                end
                else if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (ret_reg == S_REC_RD)
                    begin
                        state_next = S_REC_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        // The reconstruct hop reads the parent from S_REC_EMIT on.
        if (state_reg == S_REC_WAIT || state_reg == S_OUT)
        begin
            tbl_raddr = cur_reg;
        end
        if (state_reg == S_REC_RD)
        begin
            tbl_raddr = cur_reg;
        end
        if (state_reg == S_EXP_RD || state_reg == S_EXP_WAIT)
        begin
            tbl_raddr = node_c;
        end
        if (state_reg == S_SCAN && scan_first_reg)
        begin
            best_sum_next = '1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

// ===== src/astar_ram.sv =====
// Generic single-port-write, registered-read RAM.
module astar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/astar_cell.sv =====
// One open list cell: holds an entry and takes its upper neighbor's on removal.
module astar_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 load,       // take push record
    input  logic                 shift,      // take neighbor record
    input  astar_pkg::open_rec_t push_rec,
    input  astar_pkg::open_rec_t nbr_rec,
    input  logic                 nbr_valid,
    output astar_pkg::open_rec_t rec,
    output logic                 valid
);
    import astar_pkg::*;

    open_rec_t rec_reg;
    logic      valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (shift)
        begin
            valid_reg <= nbr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= push_rec;
        end
        else if (shift)
        begin
            rec_reg <= nbr_rec;
        end
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;
endmodule

// ===== src/astar_row.sv =====
// Row of open list cells with a rotating read port for the best-entry scan.
module astar_row
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  astar_pkg::row_ctl_t          ctl,
    input  logic [astar_pkg::OPEN_W-1:0] tail,
    input  logic [astar_pkg::OPEN_W-1:0] rd_idx,
    output astar_pkg::open_rec_t         rd_rec
);
    import astar_pkg::*;

    open_rec_t recs  [OPEN_DEPTH];
    logic      vals  [OPEN_DEPTH];

    for (genvar i = 0; i < OPEN_DEPTH; i++)
    begin : g_cell
        open_rec_t nbr;
        logic      nv;
        if (i == OPEN_DEPTH - 1)
        begin : g_end
            assign nbr = recs[i];
            assign nv  = 1'b0;
        end
        else
        begin : g_mid
            assign nbr = recs[i+1];
            assign nv  = vals[i+1];
        end
        astar_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (ctl.clear),
            .load      (ctl.push && (tail == OPEN_W'(i))),
            .shift     (ctl.remove && (OPEN_W'(i) >= ctl.remove_idx)),
            .push_rec  (ctl.push_rec),
            .nbr_rec   (nbr),
            .nbr_valid (nv),
            .rec       (recs[i]),
            .valid     (vals[i])
        );
    end

    // Scan port, one entry per cycle.
    always_ff @(posedge clk)
    begin
        rd_rec <= recs[rd_idx];
    end
endmodule
